// ===== rtl/cmb_pkg.sv =====
// shared types, constants and codes for the cross mean blur block
// no dependencies
`default_nettype none

package cmb_pkg;

  localparam int MAX_WIDTH = 128;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int CNT_W     = COL_W + 1;
  localparam int CHAN_W    = 8;
  localparam int WREG_W    = 8;
  localparam int HREG_W    = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  // operation codes carried in tuser
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // index 0 red, 1 green, 2 blue
  typedef logic [2:0][CHAN_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t upper;
    pixel_t centre;
  } entry_t;

  typedef struct packed {
    logic             live;
    logic             produce;
    logic             write;
    logic             has_up;
    logic             has_down;
    logic             has_left;
    logic             has_right;
    logic             last;
    logic [COL_W-1:0] col;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/cmb_ram.sv =====
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module cmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cmb_seq.sv =====
// input sequencer: config registers, raster position, drain count,
// per-word control and line memory read address; uses cmb_pkg
`default_nettype none

module cmb_seq (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [cmb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cmb_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                           accept,
  input  wire logic                           op,
  output      cmb_pkg::ctrl_t                 ctrl,
  output      logic [cmb_pkg::COL_W-1:0]      rd_addr
);

  logic [cmb_pkg::WREG_W-1:0] width_reg;
  logic [cmb_pkg::HREG_W-1:0] height_reg;
  logic [cmb_pkg::COL_W-1:0]  col;
  logic [cmb_pkg::HREG_W-1:0] row;
  logic [cmb_pkg::CNT_W-1:0]  pending;

  logic [cmb_pkg::CNT_W-1:0]  eff_w;
  logic [cmb_pkg::HREG_W-1:0] eff_h;
  logic [cmb_pkg::CNT_W-1:0]  col_inc;
  logic [cmb_pkg::CNT_W-1:0]  d;
  logic [cmb_pkg::CNT_W-1:0]  d_inc;
  logic [cmb_pkg::CNT_W-1:0]  nxt;
  logic [cmb_pkg::HREG_W:0]   row_inc;
  logic                       at_row_end;

  always_comb begin
    if (width_reg < cmb_pkg::WREG_W'(2)) begin
      eff_w = cmb_pkg::CNT_W'(2);
    end else if (width_reg > cmb_pkg::WREG_W'(cmb_pkg::MAX_WIDTH)) begin
      eff_w = cmb_pkg::CNT_W'(cmb_pkg::MAX_WIDTH);
    end else begin
      eff_w = cmb_pkg::CNT_W'(width_reg);
    end
  end

  assign eff_h      = (height_reg < cmb_pkg::HREG_W'(2)) ? cmb_pkg::HREG_W'(2) : height_reg;
  assign col_inc    = {1'b0, col} + cmb_pkg::CNT_W'(1);
  assign at_row_end = (col_inc == eff_w);
  assign d          = eff_w - pending;
  assign d_inc      = d + cmb_pkg::CNT_W'(1);
  assign row_inc    = {1'b0, row} + (cmb_pkg::HREG_W + 1)'(1);

  always_comb begin
    if (op == cmb_pkg::OP_PIXEL) begin
      ctrl.live      = 1'b1;
      ctrl.produce   = (row != '0);
      ctrl.write     = 1'b1;
      ctrl.has_up    = (row > cmb_pkg::HREG_W'(1));
      ctrl.has_down  = 1'b1;
      ctrl.has_left  = (col != '0);
      ctrl.has_right = !at_row_end;
      ctrl.last      = 1'b0;
      ctrl.col       = col;
      nxt            = col_inc;
    end else begin
      ctrl.live      = (pending != '0);
      ctrl.produce   = (pending != '0);
      ctrl.write     = 1'b0;
      ctrl.has_up    = 1'b1;
      ctrl.has_down  = 1'b0;
      ctrl.has_left  = (d != '0);
      ctrl.has_right = (d_inc != eff_w);
      ctrl.last      = (pending == cmb_pkg::CNT_W'(1));
      ctrl.col       = d[cmb_pkg::COL_W-1:0];
      nxt            = d_inc;
    end
  end

  // prefetch one column ahead, wrapping to column zero for the next row
  assign rd_addr = (nxt == eff_w) ? '0 : nxt[cmb_pkg::COL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= cmb_pkg::WREG_W'(128);
      height_reg <= cmb_pkg::HREG_W'(128);
      col        <= '0;
      row        <= '0;
      pending    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cmb_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data[cmb_pkg::WREG_W-1:0];
        cmb_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data[cmb_pkg::HREG_W-1:0];
        default: ;
      endcase
      col     <= '0;
      row     <= '0;
      pending <= '0;
    end else if (accept) begin
      if (op == cmb_pkg::OP_PIXEL) begin
        if (at_row_end) begin
          col <= '0;
          if (row_inc >= {1'b0, eff_h}) begin
            row     <= '0;
            pending <= eff_w;
          end else begin
            row     <= row_inc[cmb_pkg::HREG_W-1:0];
            pending <= '0;
          end
        end else begin
          col     <= col_inc[cmb_pkg::COL_W-1:0];
          pending <= '0;
        end
      end else if (pending != '0) begin
        pending <= pending - cmb_pkg::CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cmb_mean.sv =====
// five point cross mean per channel, divisor 3, 4 or 5 by reciprocal multiply
// uses cmb_pkg
`default_nettype none

module cmb_mean (
  input  wire cmb_pkg::ctrl_t  ctrl,
  input  wire cmb_pkg::pixel_t centre,
  input  wire cmb_pkg::pixel_t up,
  input  wire cmb_pkg::pixel_t down,
  input  wire cmb_pkg::pixel_t left,
  input  wire cmb_pkg::pixel_t right,
  output      cmb_pkg::pixel_t mean
);

  localparam int SUM_W = cmb_pkg::CHAN_W + 3;

  // exact for sums below 2048
  function automatic logic [cmb_pkg::CHAN_W-1:0] div3(input logic [SUM_W-1:0] x);
    logic [SUM_W+9:0] p;
    p = (SUM_W + 10)'(x) * (SUM_W + 10)'(683);
    return p[cmb_pkg::CHAN_W+10:11];
  endfunction

  // exact for sums up to 5 * 255
  function automatic logic [cmb_pkg::CHAN_W-1:0] div5(input logic [SUM_W-1:0] x);
    logic [SUM_W+10:0] p;
    p = (SUM_W + 11)'(x) * (SUM_W + 11)'(1639);
    return p[cmb_pkg::CHAN_W+12:13];
  endfunction

  logic [2:0]       n;
  logic [SUM_W-1:0] sum [3];

  assign n = 3'd1 + 3'(ctrl.has_up) + 3'(ctrl.has_down)
           + 3'(ctrl.has_left) + 3'(ctrl.has_right);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = SUM_W'(centre[k])
             + (ctrl.has_up    ? SUM_W'(up[k])    : '0)
             + (ctrl.has_down  ? SUM_W'(down[k])  : '0)
             + (ctrl.has_left  ? SUM_W'(left[k])  : '0)
             + (ctrl.has_right ? SUM_W'(right[k]) : '0);
      unique case (n)
        3'd4:    mean[k] = sum[k][cmb_pkg::CHAN_W+1:2];
        3'd5:    mean[k] = div5(sum[k]);
        default: mean[k] = div3(sum[k]);
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cross_mean_blur_rgb_core.sv =====
// top level of the five point cross mean blur over an rgb pixel stream
// uses cmb_pkg, cmb_ram, cmb_seq, cmb_mean
`default_nettype none

// Takes one word per clock, pixels or drain ticks, with no gaps needed. A
// pixel's word is looked up in a 128 x 48 line memory (row above and centre
// row per column) with a registered read; the entry for the next column is
// read one word ahead, the current and left columns sit in a small register
// window, and a write to the entry being read in the same cycle is forwarded.
// An accepted word is registered in the compute stage; its result goes to the
// output register when that stage fires, and a result waiting there unread
// holds back the input. The result for a pixel leaves when the pixel below it
// arrives; after the frame's last pixel, one drain tick per result releases
// the final row, the last one flagged on tlast. No clearing pass after reset.

module cross_mean_blur_rgb_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [cmb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cmb_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [23:0]                   s_axis_tdata,  // red_in, green_in, blue_in
  input  wire logic [0:0]                    s_axis_tuser,  // operation
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [23:0]                   m_axis_tdata,  // red_out, green_out, blue_out
  output      logic                          m_axis_tlast
);

  logic                       s_fire;
  logic                       b_fire;
  cmb_pkg::ctrl_t             a_ctrl;
  logic [cmb_pkg::COL_W-1:0]  rd_addr;

  logic                       b_valid;
  cmb_pkg::ctrl_t             b_ctrl;
  cmb_pkg::pixel_t            b_px;
  logic                       b_fwd_hit;
  cmb_pkg::entry_t            b_fwd_data;
  cmb_pkg::entry_t            ram_rdata;
  cmb_pkg::entry_t            b_next;
  cmb_pkg::entry_t            cur_entry;
  cmb_pkg::pixel_t            prev_centre;
  cmb_pkg::entry_t            wr_entry;
  cmb_pkg::pixel_t            mean;

  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign b_fire        = b_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !b_valid || b_fire;

  cmb_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (s_fire),
    .op        (s_axis_tuser[0]),
    .ctrl      (a_ctrl),
    .rd_addr   (rd_addr)
  );

  assign wr_entry = '{upper: cur_entry.centre, centre: b_px};

  cmb_ram #(
    .WIDTH ($bits(cmb_pkg::entry_t)),
    .DEPTH (cmb_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (b_fire && b_ctrl.write),
    .waddr (b_ctrl.col),
    .wdata (wr_entry),
    .re    (s_fire && a_ctrl.live),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign b_next = b_fwd_hit ? b_fwd_data : ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (s_fire) begin
      b_valid <= a_ctrl.live;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      b_ctrl     <= a_ctrl;
      b_px       <= s_axis_tdata;
      // same-cycle write to the entry being prefetched
      b_fwd_hit  <= b_fire && b_ctrl.write && (b_ctrl.col == rd_addr);
      b_fwd_data <= wr_entry;
    end
    if (b_fire) begin
      cur_entry   <= b_next;
      prev_centre <= cur_entry.centre;
    end
  end

  cmb_mean u_mean (
    .ctrl   (b_ctrl),
    .centre (cur_entry.centre),
    .up     (cur_entry.upper),
    .down   (b_px),
    .left   (prev_centre),
    .right  (b_next.centre),
    .mean   (mean)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (b_fire && b_ctrl.produce) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && b_ctrl.produce) begin
      m_axis_tdata <= mean;
      m_axis_tlast <= b_ctrl.last;
    end
  end

`ifndef SYNTHESIS
  a_last_from_drain: assert property (@(posedge clk) disable iff (rst)
    (b_fire && b_ctrl.last) |-> (b_ctrl.produce && !b_ctrl.write))
    else $error("frame end flagged on a word that is not a drain result");

  a_drain_has_upper: assert property (@(posedge clk) disable iff (rst)
    (b_fire && b_ctrl.produce && !b_ctrl.write) |-> (b_ctrl.has_up && !b_ctrl.has_down))
    else $error("drain result without the row above or with a row below");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !b_fire) |=> (b_valid && $stable(b_ctrl) && $stable(b_px)))
    else $error("stalled word in the compute stage was lost or changed");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for cross_mean_blur_rgb_core: scoreboard class with a
// line-store predictor, plus stream driver, sink and config tasks
// depends on rtl/cmb_pkg.sv and rtl/cross_mean_blur_rgb_core.sv
`timescale 1ns / 100ps

typedef struct {
  cmb_pkg::pixel_t pix;
  logic            last;
} blur_result_t;

class blur_scoreboard;
  logic [cmb_pkg::WREG_W-1:0] width_reg;
  logic [cmb_pkg::HREG_W-1:0] height_reg;
  cmb_pkg::pixel_t            upper_row [cmb_pkg::MAX_WIDTH];
  cmb_pkg::pixel_t            centre_row [cmb_pkg::MAX_WIDTH];
  int unsigned                col;
  int unsigned                row;
  int unsigned                pending;
  blur_result_t               blur_q [$];
  int unsigned                mismatches;

  function new();
    width_reg  = cmb_pkg::WREG_W'(cmb_pkg::MAX_WIDTH);
    height_reg = cmb_pkg::HREG_W'(128);
    col        = 0;
    row        = 0;
    pending    = 0;
    mismatches = 0;
    for (int i = 0; i < cmb_pkg::MAX_WIDTH; i++) begin
      upper_row[i]  = '0;
      centre_row[i] = '0;
    end
  endfunction

  function int unsigned eff_width();
    if (width_reg < 2) return 2;
    if (width_reg > cmb_pkg::MAX_WIDTH) return cmb_pkg::MAX_WIDTH;
    return width_reg;
  endfunction

  function int unsigned eff_height();
    return (height_reg < 2) ? 2 : height_reg;
  endfunction

  function int unsigned outstanding();
    return blur_q.size();
  endfunction

  function void apply_config(logic [cmb_pkg::CFG_IDX_W-1:0] idx,
                             logic [cmb_pkg::CFG_W-1:0] value);
    if (idx == cmb_pkg::REG_IMAGE_WIDTH) width_reg = value[cmb_pkg::WREG_W-1:0];
    else height_reg = value[cmb_pkg::HREG_W-1:0];
    col     = 0;
    row     = 0;
    pending = 0;
  endfunction

  function cmb_pkg::pixel_t cross_mean(cmb_pkg::pixel_t ctr, bit hu, cmb_pkg::pixel_t u,
                                       bit hd, cmb_pkg::pixel_t d,
                                       bit hl, cmb_pkg::pixel_t l,
                                       bit hr, cmb_pkg::pixel_t r);
    cmb_pkg::pixel_t res;
    int unsigned     n;
    int unsigned     sum;
    n = 1 + hu + hd + hl + hr;
    for (int k = 0; k < 3; k++) begin
      sum = ctr[k];
      if (hu) sum += u[k];
      if (hd) sum += d[k];
      if (hl) sum += l[k];
      if (hr) sum += r[k];
      res[k] = cmb_pkg::CHAN_W'(sum / n);
    end
    return res;
  endfunction

  function void note_input(logic op, cmb_pkg::pixel_t px);
    int unsigned  w;
    int unsigned  h;
    int unsigned  c;
    blur_result_t res;
    w = eff_width();
    h = eff_height();
    if (op == cmb_pkg::OP_DRAIN) begin
      if (pending == 0) return;
      if (pending > w) pending = w;
      c = w - pending;
      res.pix = cross_mean(centre_row[c], 1'b1, upper_row[c], 1'b0, '0,
                           c > 0, (c > 0) ? centre_row[c-1] : '0,
                           c + 1 < w, (c + 1 < w) ? centre_row[c+1] : '0);
      res.last = (pending == 1);
      pending--;
      blur_q.push_back(res);
    end else begin
      pending = 0;
      c = (col >= w) ? w - 1 : col;
      if (row == 0) begin
        centre_row[c] = px;
      end else begin
        // columns left of c already moved their centre entry up
        res.pix = cross_mean(centre_row[c], row > 1, upper_row[c], 1'b1, px,
                             c > 0, (c > 0) ? upper_row[c-1] : '0,
                             c + 1 < w, (c + 1 < w) ? centre_row[c+1] : '0);
        res.last = 1'b0;
        upper_row[c]  = centre_row[c];
        centre_row[c] = px;
        blur_q.push_back(res);
      end
      c++;
      if (c >= w) begin
        c = 0;
        row++;
        if (row >= h) begin
          row     = 0;
          pending = w;
        end
      end
      col = c;
    end
  endfunction

  task report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task check_result(cmb_pkg::pixel_t got, logic last);
    blur_result_t want;
    if (blur_q.size() == 0) begin
      report_mismatch($sformatf("unexpected word %h last %b", got, last));
      return;
    end
    want = blur_q.pop_front();
    if (got[0] !== want.pix[0])
      report_mismatch($sformatf("red %h, want %h", got[0], want.pix[0]));
    if (got[1] !== want.pix[1])
      report_mismatch($sformatf("green %h, want %h", got[1], want.pix[1]));
    if (got[2] !== want.pix[2])
      report_mismatch($sformatf("blue %h, want %h", got[2], want.pix[2]));
    if (last !== want.last)
      report_mismatch($sformatf("frame end %b, want %b", last, want.last));
  endtask
endclass

module tb_top;
  localparam int STALL_LIMIT = 2000;
  localparam int TARGET_ITEMS = 1400;
  localparam int SETTLE_CYCLES = 8;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [cmb_pkg::CFG_IDX_W-1:0] cfg_index = cmb_pkg::REG_IMAGE_WIDTH;
  logic [cmb_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [23:0]                   s_axis_tdata = '0;
  logic [0:0]                    s_axis_tuser = cmb_pkg::OP_PIXEL;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [23:0]                   m_axis_tdata;
  logic                          m_axis_tlast;

  blur_scoreboard sb = new();
  bit             no_gaps = 1'b0;
  int unsigned    items = 0;
  int unsigned    stalled = 0;

  cross_mean_blur_rgb_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result sink with random backpressure, plus the stall watchdog
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 26);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stalled = 0;
    end else begin
      stalled++;
      if (stalled >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic cmb_pkg::pixel_t random_pixel();
    cmb_pkg::pixel_t px;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 7))
        0: px[k] = '0;
        1: px[k] = '1;
        default: px[k] = cmb_pkg::CHAN_W'($urandom_range(0, 255));
      endcase
    end
    return px;
  endfunction

  task automatic send_word(logic op, cmb_pkg::pixel_t px);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(op, px);
    if (!no_gaps && $urandom_range(0, 99) < 26) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 26);
    end
  endtask

  // block has to be quiet before a register changes
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [cmb_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
    logic [cmb_pkg::CFG_W-1:0] data;
    data = cmb_pkg::CFG_W'(value);
    // width ignores the upper nibble, so exercise it anyway
    if (idx == cmb_pkg::REG_IMAGE_WIDTH)
      data[cmb_pkg::CFG_W-1:cmb_pkg::WREG_W] = 4'($urandom_range(0, 15));
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.apply_config(idx, data);
  endtask

  task automatic send_pixels(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      // drains mid-frame have nothing to release
      if ($urandom_range(0, 19) == 0) send_word(cmb_pkg::OP_DRAIN, random_pixel());
      send_word(cmb_pkg::OP_PIXEL, random_pixel());
    end
    items += count;
  endtask

  task automatic run_phase();
    int unsigned wraw;
    int unsigned hraw;
    int unsigned w;
    int unsigned h;
    int unsigned drains;
    case ($urandom_range(0, 19))
      0: wraw = 0;
      1: wraw = 1;
      2: wraw = cmb_pkg::MAX_WIDTH;
      3: wraw = $urandom_range(cmb_pkg::MAX_WIDTH + 1, 255);
      4: wraw = 2;
      default: wraw = $urandom_range(2, 10);
    endcase
    case ($urandom_range(0, 19))
      0: hraw = 0;
      1: hraw = 1;
      2: hraw = 4095;
      3: hraw = $urandom_range(2, 4095);
      default: hraw = $urandom_range(2, 6);
    endcase
    if ($urandom_range(0, 1)) begin
      write_reg(cmb_pkg::REG_IMAGE_WIDTH, wraw);
      write_reg(cmb_pkg::REG_IMAGE_HEIGHT, hraw);
    end else begin
      write_reg(cmb_pkg::REG_IMAGE_HEIGHT, hraw);
      write_reg(cmb_pkg::REG_IMAGE_WIDTH, wraw);
    end
    w = sb.eff_width();
    h = sb.eff_height();
    if (w * h > 300) begin
      // tall or wide frame: run part of it, the next write restarts anyway
      send_pixels($urandom_range(2 * w, (2 * w > 300) ? 2 * w : 300));
    end else begin
      repeat ($urandom_range(1, 3)) begin
        send_pixels(w * h);
        case ($urandom_range(0, 9))
          0: drains = $urandom_range(0, w - 1);
          1: drains = w + $urandom_range(1, 3);
          default: drains = w;
        endcase
        repeat (drains) send_word(cmb_pkg::OP_DRAIN, random_pixel());
        items += drains;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // widths below two clamp up, heights below two clamp up: all corners
    write_reg(cmb_pkg::REG_IMAGE_WIDTH, 0);
    write_reg(cmb_pkg::REG_IMAGE_HEIGHT, 1);
    send_word(cmb_pkg::OP_DRAIN, '0);
    send_word(cmb_pkg::OP_PIXEL, '1);
    send_word(cmb_pkg::OP_PIXEL, '0);
    send_word(cmb_pkg::OP_PIXEL, 24'h00ff00);
    send_word(cmb_pkg::OP_PIXEL, 24'hff00ff);
    repeat (3) send_word(cmb_pkg::OP_DRAIN, '1);

    // saturated 3x3 frame, then a pixel that cuts the drain short
    write_reg(cmb_pkg::REG_IMAGE_WIDTH, 3);
    write_reg(cmb_pkg::REG_IMAGE_HEIGHT, 3);
    repeat (9) send_word(cmb_pkg::OP_PIXEL, '1);
    send_word(cmb_pkg::OP_DRAIN, '0);
    send_word(cmb_pkg::OP_PIXEL, random_pixel());
    send_word(cmb_pkg::OP_DRAIN, '0);
    items = 20;

    while (items < TARGET_ITEMS) begin
      no_gaps = (items >= 500 && items < 800);
      run_phase();
    end
    no_gaps = 1'b0;

    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/cmb_pkg.sv
rtl/cmb_ram.sv
rtl/cmb_seq.sv
rtl/cmb_mean.sv
rtl/cross_mean_blur_rgb_core.sv
tb/tb_top.sv
